FILE: src/bsi_pkg.sv
// Shared types, widths and arithmetic helpers for the boid steering integrator.
// No dependencies; imported by every module of the block.
package bsi_pkg;

   typedef logic signed [31:0] q16_type;

   // Default behavior constants (pixels, Q8.8 gains).
   localparam int SEP_GAIN_DEF       = 256;
   localparam int ALIGN_GAIN_DEF     = 256;
   localparam int EDGE_MARGIN_DEF    = 8;
   localparam int SCREEN_WIDTH_DEF   = 1024;
   localparam int SCREEN_HEIGHT_DEF  = 768;
   localparam int TOP_BAR_HEIGHT_DEF = 64;

   // Distances at or below this raw value count as sitting on the target.
   localparam logic [31:0] FLEE_MIN_RAW = 32'd65;

   // Square root unit: 64-bit radicand, 32-bit root.
   localparam int unsigned RAD_WIDTH  = 64;
   localparam int unsigned ROOT_WIDTH = RAD_WIDTH / 2;

   // Divider: 63-bit numerator, 32-bit divisor, quotient known to fit 31 bits.
   localparam int unsigned NUM_WIDTH = 63;
   localparam int unsigned DEN_WIDTH = 32;
   localparam int unsigned QUO_WIDTH = NUM_WIDTH - DEN_WIDTH;
   localparam int unsigned DIV_LANES = 2;

   // Configuration register indexes.
   localparam logic [2:0] REG_FLEE_RADIUS   = 3'd0;
   localparam logic [2:0] REG_STEERING_GAIN = 3'd1;
   localparam logic [2:0] REG_MAX_FORCE     = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED     = 3'd3;
   localparam logic [2:0] REG_TARGET_X      = 3'd4;
   localparam logic [2:0] REG_TARGET_Y      = 3'd5;
   localparam logic [2:0] REG_STEP_TIME     = 3'd6;

   function automatic q16_type sat32(input logic signed [63:0] v);
      q16_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Arithmetic shift right that truncates toward zero.
   function automatic logic signed [63:0] shr_zero(input logic signed [63:0] v,
                                                   input int unsigned sh);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (v + bias) >>> sh;
   endfunction

   function automatic q16_type neg32(input q16_type v);
      q16_type r;
      r = (v == 32'sh80000000) ? 32'sh7FFFFFFF : -v;
      return r;
   endfunction

   function automatic logic [31:0] mag32(input q16_type v);
      logic [31:0] r;
      r = v[31] ? unsigned'(-v) : unsigned'(v);
      return r;
   endfunction

   function automatic q16_type apply_sign(input logic neg, input logic [QUO_WIDTH-1:0] q);
      q16_type m;
      m = q16_type'({1'b0, q});
      return neg ? -m : m;
   endfunction

endpackage

FILE: src/bsi_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on bsi_pkg; carries an opaque payload alongside each radicand.
module bsi_isqrt #(
   parameter int unsigned PAY_WIDTH = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [bsi_pkg::RAD_WIDTH-1:0]     in_radicand,
   input  logic [PAY_WIDTH-1:0]              in_payload,
   output logic                              out_valid,
   output logic [bsi_pkg::ROOT_WIDTH-1:0]    out_root,
   output logic [PAY_WIDTH-1:0]              out_payload
);
   import bsi_pkg::*;

   localparam int unsigned REM_WIDTH = ROOT_WIDTH + 2;

   logic                  vld_ff  [ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rad_ff  [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];
   logic [PAY_WIDTH-1:0]  pay_ff  [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      logic                  vld_src;
      logic [RAD_WIDTH-1:0]  rad_src;
      logic [REM_WIDTH-1:0]  rem_src;
      logic [ROOT_WIDTH-1:0] root_src;
      logic [PAY_WIDTH-1:0]  pay_src;
      logic [REM_WIDTH+1:0]  trial;
      logic [REM_WIDTH+1:0]  sub;
      logic                  take;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = in_radicand;
         assign rem_src  = '0;
         assign root_src = '0;
         assign pay_src  = in_payload;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign pay_src  = pay_ff[k-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      assign trial = {rem_src, rad_src[RAD_WIDTH-1 -: 2]};
      assign sub   = {2'b00, root_src, 2'b01};
      assign take  = (trial >= sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rad_ff[k]  <= {rad_src[RAD_WIDTH-3:0], 2'b00};
         pay_ff[k]  <= pay_src;
         root_ff[k] <= {root_src[ROOT_WIDTH-2:0], take};
         rem_ff[k]  <= take ? REM_WIDTH'(trial - sub) : trial[REM_WIDTH-1:0];
      end
   end

   assign out_valid   = vld_ff[ROOT_WIDTH-1];
   assign out_root    = root_ff[ROOT_WIDTH-1];
   assign out_payload = pay_ff[ROOT_WIDTH-1];

endmodule

FILE: src/bsi_div2.sv
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
// Depends on bsi_pkg; the caller guarantees each quotient fits QUO_WIDTH bits.
module bsi_div2 #(
   parameter int unsigned PAY_WIDTH = 1
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   in_valid,
   input  logic [bsi_pkg::DIV_LANES-1:0][bsi_pkg::NUM_WIDTH-1:0]  in_num,
   input  logic [bsi_pkg::DEN_WIDTH-1:0]                          in_den,
   input  logic [PAY_WIDTH-1:0]                                   in_payload,
   output logic                                                   out_valid,
   output logic [bsi_pkg::DIV_LANES-1:0][bsi_pkg::QUO_WIDTH-1:0]  out_quo,
   output logic [PAY_WIDTH-1:0]                                   out_payload
);
   import bsi_pkg::*;

   logic                                   vld_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]                   den_ff [QUO_WIDTH];
   logic [DIV_LANES-1:0][DEN_WIDTH-1:0]    rem_ff [QUO_WIDTH];
   logic [DIV_LANES-1:0][QUO_WIDTH-1:0]    low_ff [QUO_WIDTH];
   logic [DIV_LANES-1:0][QUO_WIDTH-1:0]    quo_ff [QUO_WIDTH];
   logic [PAY_WIDTH-1:0]                   pay_ff [QUO_WIDTH];

   for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_step
      logic                                vld_src;
      logic [DEN_WIDTH-1:0]                den_src;
      logic [DIV_LANES-1:0][DEN_WIDTH-1:0] rem_src;
      logic [DIV_LANES-1:0][QUO_WIDTH-1:0] low_src;
      logic [DIV_LANES-1:0][QUO_WIDTH-1:0] quo_src;
      logic [PAY_WIDTH-1:0]                pay_src;
      logic [DIV_LANES-1:0][DEN_WIDTH:0]   trial;
      logic [DIV_LANES-1:0]                take;
      logic [DIV_LANES-1:0][DEN_WIDTH-1:0] rem_in;
      logic [DIV_LANES-1:0][QUO_WIDTH-1:0] low_in;
      logic [DIV_LANES-1:0][QUO_WIDTH-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign den_src = in_den;
         assign pay_src = in_payload;
         for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
            assign rem_src[l] = in_num[l][NUM_WIDTH-1:QUO_WIDTH];
            assign low_src[l] = in_num[l][QUO_WIDTH-1:0];
            assign quo_src[l] = '0;
         end
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign den_src = den_ff[k-1];
         assign pay_src = pay_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < DIV_LANES; l++) begin
            trial[l]  = {rem_src[l], low_src[l][QUO_WIDTH-1]};
            take[l]   = (trial[l] >= {1'b0, den_src});
            rem_in[l] = take[l] ? DEN_WIDTH'(trial[l] - {1'b0, den_src})
                                : trial[l][DEN_WIDTH-1:0];
            low_in[l] = {low_src[l][QUO_WIDTH-2:0], 1'b0};
            quo_in[l] = {quo_src[l][QUO_WIDTH-2:0], take[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         den_ff[k] <= den_src;
         pay_ff[k] <= pay_src;
         rem_ff[k] <= rem_in;
         low_ff[k] <= low_in;
         quo_ff[k] <= quo_in;
      end
   end

   assign out_valid   = vld_ff[QUO_WIDTH-1];
   assign out_quo     = quo_ff[QUO_WIDTH-1];
   assign out_payload = pay_ff[QUO_WIDTH-1];

endmodule

FILE: src/boid_steering_integrator.sv
// Boid steering and Euler step: flee, separation/alignment, force and speed clamps, walls.
// Depends on bsi_pkg, bsi_isqrt and bsi_div2.
//
//   channel   ports                            handshake
//   request   req_*  (one agent per word)      taken when start high and busy low
//   response  rsp_*  (one updated agent)       rsp_valid strobe, one cycle, no back-pressure
//   config    csr_we, csr_index, csr_wdata     written on an edge with csr_we high and reset low
//
// One word enters per cycle. The pipeline is built from three square roots
// (32 stages each) and three two-lane dividers (31 stages each), all one bit
// per stage. busy never rises, so start may be held high to stream agents.
// Reset clears every valid bit and loads the config register defaults; words
// in flight are dropped. Nothing stalls: every stage advances each cycle
// because the receiver always takes the response.
module boid_steering_integrator #(
   parameter int SEP_GAIN       = bsi_pkg::SEP_GAIN_DEF,
   parameter int ALIGN_GAIN     = bsi_pkg::ALIGN_GAIN_DEF,
   parameter int EDGE_MARGIN    = bsi_pkg::EDGE_MARGIN_DEF,
   parameter int SCREEN_WIDTH   = bsi_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT  = bsi_pkg::SCREEN_HEIGHT_DEF,
   parameter int TOP_BAR_HEIGHT = bsi_pkg::TOP_BAR_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bsi_pkg::q16_type     req_pos_x,
   input  bsi_pkg::q16_type     req_pos_y,
   input  bsi_pkg::q16_type     req_vel_x,
   input  bsi_pkg::q16_type     req_vel_y,
   input  logic [30:0]          req_flee_speed,
   input  bsi_pkg::q16_type     req_repel_x,
   input  bsi_pkg::q16_type     req_repel_y,
   input  bsi_pkg::q16_type     req_mean_vel_x,
   input  bsi_pkg::q16_type     req_mean_vel_y,
   input  logic                 req_last_agent,
   output logic                 rsp_valid,
   output bsi_pkg::q16_type     rsp_new_pos_x,
   output bsi_pkg::q16_type     rsp_new_pos_y,
   output bsi_pkg::q16_type     rsp_new_vel_x,
   output bsi_pkg::q16_type     rsp_new_vel_y,
   output logic                 rsp_done_res,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import bsi_pkg::*;

   // Wall positions in Q16.16; the parameter ranges keep these inside 32 bits.
   localparam q16_type RIGHT_WALL  = q16_type'((SCREEN_WIDTH - EDGE_MARGIN) * 65536);
   localparam q16_type LEFT_WALL   = q16_type'(EDGE_MARGIN * 65536);
   localparam q16_type BOTTOM_WALL = q16_type'((SCREEN_HEIGHT - EDGE_MARGIN) * 65536);
   localparam q16_type TOP_WALL    = q16_type'((TOP_BAR_HEIGHT + EDGE_MARGIN) * 65536);
   localparam logic signed [63:0] SEP_GAIN_S   = 64'(SEP_GAIN);
   localparam logic signed [63:0] ALIGN_GAIN_S = 64'(ALIGN_GAIN);

   // Position/velocity context that rides along most of the pipe.
   typedef struct packed {
      q16_type px, py, vx, vy;
      logic    last;
   } mot_type;

   typedef struct packed {
      q16_type     dx, dy, rx, ry, mx, my;
      logic [30:0] fs;
      mot_type     m;
   } sa_type;

   typedef struct packed {
      logic [63:0]        dxx, dyy;
      logic signed [63:0] prx, pry, pmx, pmy;
      q16_type            dx, dy;
      logic [30:0]        fs;
      mot_type            m;
   } sb_type;

   typedef struct packed {
      logic [63:0] s;
      q16_type     rsx, rsy, msx, msy, dx, dy;
      logic [30:0] fs;
      mot_type     m;
   } sc_type;

   typedef struct packed {
      q16_type            dx, dy;
      logic signed [32:0] tx, ty;
      logic [30:0]        fs;
      mot_type            m;
   } p1_type;

   typedef struct packed {
      logic               flee, sdx, sdy;
      logic signed [32:0] tx, ty;
      mot_type            m;
   } p2_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0]                den;
      p2_type                              c;
   } sd_type;

   typedef struct packed {
      q16_type wx, wy;
      mot_type m;
   } se_type;

   typedef struct packed {
      logic signed [32:0] ex, ey;
      mot_type            m;
   } sf_type;

   typedef struct packed {
      logic signed [57:0] gx, gy;
      mot_type            m;
   } sg_type;

   typedef struct packed {
      q16_type ax, ay;
      mot_type m;
   } acc_type;

   typedef struct packed {
      logic [63:0] xx, yy;
      acc_type     c;
   } si_type;

   typedef struct packed {
      logic [63:0] s;
      acc_type     c;
   } sj_type;

   typedef struct packed {
      logic    over;
      acc_type c;
   } p3_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0]                den;
      p3_type                              c;
   } sk_type;

   typedef struct packed {
      logic signed [49:0] gx, gy;
      mot_type            m;
   } dtp_type;

   typedef struct packed {
      logic [63:0] xx, yy;
      mot_type     m;
   } so_type;

   typedef struct packed {
      logic [63:0] s;
      mot_type     m;
   } sp_type;

   typedef struct packed {
      logic    over;
      mot_type m;
   } p5_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0]                den;
      p5_type                              c;
   } sq_type;

   // ---------------------------------------------------------------- config
   logic [30:0]       flee_radius_ff;
   logic [24:0]       steering_gain_ff;
   logic [30:0]       max_force_ff;
   logic [30:0]       max_speed_ff;
   q16_type           target_x_ff;
   q16_type           target_y_ff;
   logic [16:0]       step_time_ff;
   logic [61:0]       force_sq_ff;
   logic [61:0]       speed_sq_ff;
   logic signed [17:0] dt_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         flee_radius_ff   <= 31'd6553600;
         steering_gain_ff <= 25'd65536;
         max_force_ff     <= 31'd13107200;
         max_speed_ff     <= 31'd655360;
         target_x_ff      <= '0;
         target_y_ff      <= '0;
         step_time_ff     <= 17'd1092;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FLEE_RADIUS:   flee_radius_ff   <= csr_wdata[30:0];
            REG_STEERING_GAIN: steering_gain_ff <= csr_wdata[24:0];
            REG_MAX_FORCE:     max_force_ff     <= csr_wdata[30:0];
            REG_MAX_SPEED:     max_speed_ff     <= csr_wdata[30:0];
            REG_TARGET_X:      target_x_ff      <= csr_wdata;
            REG_TARGET_Y:      target_y_ff      <= csr_wdata;
            REG_STEP_TIME:     step_time_ff     <= csr_wdata[16:0];
            default:           ;  // drop writes to unused indexes
         endcase
      end
   end

   // Squared limits are registered from the bounds and follow them in the next
   // cycle; a word reaches the compares only after the distance square root.
   always_ff @(posedge clock) begin
      force_sq_ff <= 62'(64'(max_force_ff) * 64'(max_force_ff));
      speed_sq_ff <= 62'(64'(max_speed_ff) * 64'(max_speed_ff));
   end

   assign dt_s = signed'({1'b0, step_time_ff});

   // The pipe takes a word every cycle.
   assign busy = 1'b0;

   // ------------------------------------------------- A: offset from target
   sa_type a_in, a_ff;
   logic   a_v_ff;

   always_comb begin
      a_in.dx     = sat32(64'(req_pos_x) - 64'(target_x_ff));
      a_in.dy     = sat32(64'(req_pos_y) - 64'(target_y_ff));
      a_in.rx     = req_repel_x;
      a_in.ry     = req_repel_y;
      a_in.mx     = req_mean_vel_x;
      a_in.my     = req_mean_vel_y;
      a_in.fs     = req_flee_speed;
      a_in.m.px   = req_pos_x;
      a_in.m.py   = req_pos_y;
      a_in.m.vx   = req_vel_x;
      a_in.m.vy   = req_vel_y;
      a_in.m.last = req_last_agent;
   end

   // ------------------------------------- B: squares and gain products
   sb_type b_in, b_ff;
   logic   b_v_ff;

   always_comb begin
      b_in.dxx = unsigned'(64'(a_ff.dx) * 64'(a_ff.dx));
      b_in.dyy = unsigned'(64'(a_ff.dy) * 64'(a_ff.dy));
      b_in.prx = 64'(a_ff.rx) * SEP_GAIN_S;
      b_in.pry = 64'(a_ff.ry) * SEP_GAIN_S;
      b_in.pmx = 64'(a_ff.mx) * ALIGN_GAIN_S;
      b_in.pmy = 64'(a_ff.my) * ALIGN_GAIN_S;
      b_in.dx  = a_ff.dx;
      b_in.dy  = a_ff.dy;
      b_in.fs  = a_ff.fs;
      b_in.m   = a_ff.m;
   end

   // ------------------------------- C: distance squared, Q8.8 rescale
   sc_type c_in, c_ff;
   logic   c_v_ff;

   always_comb begin
      c_in.s   = b_ff.dxx + b_ff.dyy;
      c_in.rsx = sat32(shr_zero(b_ff.prx, 8));
      c_in.rsy = sat32(shr_zero(b_ff.pry, 8));
      c_in.msx = sat32(shr_zero(b_ff.pmx, 8));
      c_in.msy = sat32(shr_zero(b_ff.pmy, 8));
      c_in.dx  = b_ff.dx;
      c_in.dy  = b_ff.dy;
      c_in.fs  = b_ff.fs;
      c_in.m   = b_ff.m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start & ~busy;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
   end

   // ------------------------------------------ distance to the target
   p1_type      p1_in, p1_out;
   logic        r1_v;
   logic [31:0] r1_root;

   always_comb begin
      p1_in.dx = c_ff.dx;
      p1_in.dy = c_ff.dy;
      p1_in.tx = 33'(c_ff.rsx) + 33'(c_ff.msx);
      p1_in.ty = 33'(c_ff.rsy) + 33'(c_ff.msy);
      p1_in.fs = c_ff.fs;
      p1_in.m  = c_ff.m;
   end

   bsi_isqrt #(.PAY_WIDTH($bits(p1_type))) u_dist_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c_v_ff),
      .in_radicand (c_ff.s),
      .in_payload  (p1_in),
      .out_valid   (r1_v),
      .out_root    (r1_root),
      .out_payload (p1_out)
   );

   // ------------------------------- D: flee test, flee-speed products
   sd_type d_in, d_ff;
   logic   d_v_ff;

   always_comb begin
      d_in.num[0] = NUM_WIDTH'(64'(mag32(p1_out.dx)) * 64'(p1_out.fs));
      d_in.num[1] = NUM_WIDTH'(64'(mag32(p1_out.dy)) * 64'(p1_out.fs));
      d_in.den    = r1_root;
      d_in.c.flee = (r1_root > FLEE_MIN_RAW) && (r1_root < 32'(flee_radius_ff));
      d_in.c.sdx  = p1_out.dx[31];
      d_in.c.sdy  = p1_out.dy[31];
      d_in.c.tx   = p1_out.tx;
      d_in.c.ty   = p1_out.ty;
      d_in.c.m    = p1_out.m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else begin
         d_v_ff <= r1_v;
      end
      d_ff <= d_in;
   end

   p2_type                              p2_out;
   logic                                q1_v;
   logic [DIV_LANES-1:0][QUO_WIDTH-1:0] q1_quo;

   bsi_div2 #(.PAY_WIDTH($bits(p2_type))) u_flee_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_v_ff),
      .in_num      (d_ff.num),
      .in_den      (d_ff.den),
      .in_payload  (d_ff.c),
      .out_valid   (q1_v),
      .out_quo     (q1_quo),
      .out_payload (p2_out)
   );

   // ---------------------------------------- E: desired velocity
   se_type  e_in, e_ff;
   logic    e_v_ff;
   q16_type fvx, fvy;

   always_comb begin
      fvx     = p2_out.flee ? apply_sign(p2_out.sdx, q1_quo[0]) : '0;
      fvy     = p2_out.flee ? apply_sign(p2_out.sdy, q1_quo[1]) : '0;
      e_in.wx = sat32(64'(fvx) + 64'(p2_out.tx));
      e_in.wy = sat32(64'(fvy) + 64'(p2_out.ty));
      e_in.m  = p2_out.m;
   end

   // ------------------------------------ F: velocity error
   sf_type f_in, f_ff;
   logic   f_v_ff;

   always_comb begin
      f_in.ex = 33'(e_ff.wx) - 33'(e_ff.m.vx);
      f_in.ey = 33'(e_ff.wy) - 33'(e_ff.m.vy);
      f_in.m  = e_ff.m;
   end

   // ------------------------------------ G: steering gain product
   sg_type             g_in, g_ff;
   logic               g_v_ff;
   logic signed [57:0] gain_s;

   always_comb begin
      gain_s  = 58'(signed'({1'b0, steering_gain_ff}));
      g_in.gx = 58'(f_ff.ex) * gain_s;
      g_in.gy = 58'(f_ff.ey) * gain_s;
      g_in.m  = f_ff.m;
   end

   // ------------------------------------ H: steering acceleration
   acc_type h_in, h_ff;
   logic    h_v_ff;

   always_comb begin
      h_in.ax = sat32(shr_zero(64'(g_ff.gx), 16));
      h_in.ay = sat32(shr_zero(64'(g_ff.gy), 16));
      h_in.m  = g_ff.m;
   end

   // ------------------------------------ I, J: force magnitude squared
   si_type i_in, i_ff;
   sj_type j_in, j_ff;
   logic   i_v_ff, j_v_ff;

   always_comb begin
      i_in.xx = unsigned'(64'(h_ff.ax) * 64'(h_ff.ax));
      i_in.yy = unsigned'(64'(h_ff.ay) * 64'(h_ff.ay));
      i_in.c  = h_ff;
      j_in.s  = i_ff.xx + i_ff.yy;
      j_in.c  = i_ff.c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
      end else begin
         e_v_ff <= q1_v;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         i_v_ff <= h_v_ff;
         j_v_ff <= i_v_ff;
      end
      e_ff <= e_in;
      f_ff <= f_in;
      g_ff <= g_in;
      h_ff <= h_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end

   // ------------------------------------------ force magnitude
   p3_type      p3_in, p3_out;
   logic        r2_v;
   logic [31:0] r2_root;

   always_comb begin
      p3_in.over = (j_ff.s > 64'(force_sq_ff));
      p3_in.c    = j_ff.c;
   end

   bsi_isqrt #(.PAY_WIDTH($bits(p3_type))) u_force_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (j_v_ff),
      .in_radicand (j_ff.s),
      .in_payload  (p3_in),
      .out_valid   (r2_v),
      .out_root    (r2_root),
      .out_payload (p3_out)
   );

   // ------------------------------------------ K: force clamp products
   sk_type k_in, k_ff;
   logic   k_v_ff;

   always_comb begin
      k_in.num[0] = NUM_WIDTH'(64'(mag32(p3_out.c.ax)) * 64'(max_force_ff));
      k_in.num[1] = NUM_WIDTH'(64'(mag32(p3_out.c.ay)) * 64'(max_force_ff));
      k_in.den    = r2_root;
      k_in.c      = p3_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else begin
         k_v_ff <= r2_v;
      end
      k_ff <= k_in;
   end

   p3_type                              p4_out;
   logic                                q2_v;
   logic [DIV_LANES-1:0][QUO_WIDTH-1:0] q2_quo;

   bsi_div2 #(.PAY_WIDTH($bits(p3_type))) u_force_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (k_v_ff),
      .in_num      (k_ff.num),
      .in_den      (k_ff.den),
      .in_payload  (k_ff.c),
      .out_valid   (q2_v),
      .out_quo     (q2_quo),
      .out_payload (p4_out)
   );

   // ------------------------------------------ L: clamped force
   acc_type l_in, l_ff;
   logic    l_v_ff;

   always_comb begin
      l_in = p4_out.c;
      if (p4_out.over) begin
         l_in.ax = apply_sign(p4_out.c.ax[31], q2_quo[0]);
         l_in.ay = apply_sign(p4_out.c.ay[31], q2_quo[1]);
      end
   end

   // ------------------------------------------ M, N: integrate velocity
   dtp_type m_in, m_ff;
   mot_type n_in, n_ff;
   logic    m_v_ff, n_v_ff;

   always_comb begin
      m_in.gx = 50'(dt_s) * 50'(l_ff.ax);
      m_in.gy = 50'(dt_s) * 50'(l_ff.ay);
      m_in.m  = l_ff.m;
      n_in    = m_ff.m;
      n_in.vx = sat32(64'(m_ff.m.vx) + shr_zero(64'(m_ff.gx), 16));
      n_in.vy = sat32(64'(m_ff.m.vy) + shr_zero(64'(m_ff.gy), 16));
   end

   // ------------------------------------------ O, P: speed squared
   so_type o_in, o_ff;
   sp_type p_in, p_ff;
   logic   o_v_ff, p_v_ff;

   always_comb begin
      o_in.xx = unsigned'(64'(n_ff.vx) * 64'(n_ff.vx));
      o_in.yy = unsigned'(64'(n_ff.vy) * 64'(n_ff.vy));
      o_in.m  = n_ff;
      p_in.s  = o_ff.xx + o_ff.yy;
      p_in.m  = o_ff.m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         n_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
      end else begin
         l_v_ff <= q2_v;
         m_v_ff <= l_v_ff;
         n_v_ff <= m_v_ff;
         o_v_ff <= n_v_ff;
         p_v_ff <= o_v_ff;
      end
      l_ff <= l_in;
      m_ff <= m_in;
      n_ff <= n_in;
      o_ff <= o_in;
      p_ff <= p_in;
   end

   // ------------------------------------------ speed magnitude
   p5_type      p5_in, p5_out;
   logic        r3_v;
   logic [31:0] r3_root;

   always_comb begin
      p5_in.over = (p_ff.s > 64'(speed_sq_ff));
      p5_in.m    = p_ff.m;
   end

   bsi_isqrt #(.PAY_WIDTH($bits(p5_type))) u_speed_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (p_v_ff),
      .in_radicand (p_ff.s),
      .in_payload  (p5_in),
      .out_valid   (r3_v),
      .out_root    (r3_root),
      .out_payload (p5_out)
   );

   // ------------------------------------------ Q: speed clamp products
   sq_type q_in, q_ff;
   logic   q_v_ff;

   always_comb begin
      q_in.num[0] = NUM_WIDTH'(64'(mag32(p5_out.m.vx)) * 64'(max_speed_ff));
      q_in.num[1] = NUM_WIDTH'(64'(mag32(p5_out.m.vy)) * 64'(max_speed_ff));
      q_in.den    = r3_root;
      q_in.c      = p5_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else begin
         q_v_ff <= r3_v;
      end
      q_ff <= q_in;
   end

   p5_type                              p6_out;
   logic                                q3_v;
   logic [DIV_LANES-1:0][QUO_WIDTH-1:0] q3_quo;

   bsi_div2 #(.PAY_WIDTH($bits(p5_type))) u_speed_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_v_ff),
      .in_num      (q_ff.num),
      .in_den      (q_ff.den),
      .in_payload  (q_ff.c),
      .out_valid   (q3_v),
      .out_quo     (q3_quo),
      .out_payload (p6_out)
   );

   // ------------------------------- R: clamped speed; S, T: integrate position
   mot_type r_in, r_ff;
   dtp_type s_in, s_ff;
   mot_type t_in, t_ff;
   logic    r_v_ff, s_v_ff, t_v_ff;

   always_comb begin
      r_in = p6_out.m;
      if (p6_out.over) begin
         r_in.vx = apply_sign(p6_out.m.vx[31], q3_quo[0]);
         r_in.vy = apply_sign(p6_out.m.vy[31], q3_quo[1]);
      end
      s_in.gx = 50'(dt_s) * 50'(r_ff.vx);
      s_in.gy = 50'(dt_s) * 50'(r_ff.vy);
      s_in.m  = r_ff;
      t_in    = s_ff.m;
      t_in.px = sat32(64'(s_ff.m.px) + shr_zero(64'(s_ff.gx), 16));
      t_in.py = sat32(64'(s_ff.m.py) + shr_zero(64'(s_ff.gy), 16));
   end

   // ------------------------------------------ U: walls, response register
   mot_type u_in, u_ff;
   logic    u_v_ff;

   // Walls in order right, left, bottom, top; a narrow screen can hit both
   // walls of one axis and flip the velocity twice.
   always_comb begin
      u_in = t_ff;
      if (u_in.px > RIGHT_WALL) begin
         u_in.px = RIGHT_WALL;
         u_in.vx = neg32(u_in.vx);
      end
      if (u_in.px < LEFT_WALL) begin
         u_in.px = LEFT_WALL;
         u_in.vx = neg32(u_in.vx);
      end
      if (u_in.py > BOTTOM_WALL) begin
         u_in.py = BOTTOM_WALL;
         u_in.vy = neg32(u_in.vy);
      end
      if (u_in.py < TOP_WALL) begin
         u_in.py = TOP_WALL;
         u_in.vy = neg32(u_in.vy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
         t_v_ff <= 1'b0;
         u_v_ff <= 1'b0;
      end else begin
         r_v_ff <= q3_v;
         s_v_ff <= r_v_ff;
         t_v_ff <= s_v_ff;
         u_v_ff <= t_v_ff;
      end
      r_ff <= r_in;
      s_ff <= s_in;
      t_ff <= t_in;
      u_ff <= u_in;
   end

   assign rsp_valid     = u_v_ff;
   assign rsp_new_pos_x = u_ff.px;
   assign rsp_new_pos_y = u_ff.py;
   assign rsp_new_vel_x = u_ff.vx;
   assign rsp_new_vel_y = u_ff.vy;
   assign rsp_done_res  = u_ff.last;

endmodule
